@@ rtl/pdwp_pkg.sv @@
// Package for pixel_depth_to_world_point: register indexes, widths and constants.
// No dependencies.
package pdwp_pkg;
   localparam int CoefFracBitsDefault = 14;

   localparam logic [2:0] RegFocalX  = 3'd0;
   localparam logic [2:0] RegFocalY  = 3'd1;
   localparam logic [2:0] RegCenterX = 3'd2;
   localparam logic [2:0] RegCenterY = 3'd3;
   localparam logic [2:0] RegRowX    = 3'd4;
   localparam logic [2:0] RegRowY    = 3'd5;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 64;

   // D < 2^66, so S < 2^33; 34 root bits
   localparam int DWidth    = 66;
   localparam int SWidth    = 34;
   // numerators range*a < 2^15 * 2^32
   localparam int NumWidth  = 48;
   localparam int QWidth    = 16;

   typedef struct packed {
      logic [15:0] focal_x;
      logic [15:0] focal_y;
      logic [15:0] center_x;
      logic [15:0] center_y;
      logic [63:0] row_x;
      logic [63:0] row_y;
   } cfg_type;

   typedef struct packed {
      logic        nx;
      logic        ny;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [14:0] range;
   } geo_type;
endpackage

@@ rtl/pdwp_if.sv @@
// Valid/ready channel interface carrying a packed payload.
// Depends on nothing.
interface pdwp_if #(parameter int Width = 8);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/pdwp_sqrt.sv @@
// Pipelined floor square root, one result bit per stage, with a stall-safe
// sideband carried along. Depends on pdwp_pkg.
module pdwp_sqrt
   import pdwp_pkg::*;
#(
   parameter int SideWidth = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [DWidth-1:0]    in_d,
   input  logic [SideWidth-1:0] in_side,
   output logic                 out_valid,
   output logic [SWidth-1:0]    out_s,
   output logic [SideWidth-1:0] out_side
);
   logic [SideWidth-1:0] side_ff [SWidth+1];
   logic [DWidth-1:0]    rem_ff  [SWidth+1];
   logic [SWidth-1:0]    root_ff [SWidth+1];
   logic                 vld_ff  [SWidth+1];

   always_comb begin
      side_ff[0] = in_side;
      rem_ff[0]  = in_d;
      root_ff[0] = '0;
      vld_ff[0]  = in_valid;
   end

   for (genvar g = 0; g < SWidth; g++) begin : g_stage
      localparam int Bit = SWidth - 1 - g;
      logic [DWidth+1:0] trial;
      logic [DWidth+1:0] rem_x;
      logic              take;
      logic [SWidth-1:0] root_in;
      logic [DWidth-1:0] rem_in;
      // (r + 2^b)^2 - r^2 = 2^(b+1) r + 2^(2b)
      always_comb begin
         trial = ({{(DWidth+2-SWidth){1'b0}}, root_ff[g]} << (Bit + 1))
               | ((DWidth+2)'(1) << (2 * Bit));
         rem_x = {2'b00, rem_ff[g]};
         take  = (trial <= rem_x);
         root_in = take ? (root_ff[g] | (SWidth'(1) << Bit)) : root_ff[g];
         rem_in  = take ? DWidth'(rem_x - trial) : rem_ff[g];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[g+1] <= vld_ff[g];
         end
         if (advance) begin
            root_ff[g+1] <= root_in;
            rem_ff[g+1]  <= rem_in;
            side_ff[g+1] <= side_ff[g];
         end
      end
   end

   assign out_valid = vld_ff[SWidth];
   assign out_s     = root_ff[SWidth];
   assign out_side  = side_ff[SWidth];
endmodule

@@ rtl/pdwp_div.sv @@
// Pipelined restoring divider: quotient of a 49-bit numerator by a 35-bit divisor,
// one quotient bit per stage, with sideband. Depends on pdwp_pkg.
module pdwp_div
   import pdwp_pkg::*;
#(
   parameter int SideWidth = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [NumWidth:0]    in_num,
   input  logic [SWidth:0]      in_den,
   input  logic [SideWidth-1:0] in_side,
   output logic                 out_valid,
   output logic [QWidth-1:0]    out_q,
   output logic [SideWidth-1:0] out_side
);
   // the quotient is known below 2^16, so only 16 bits are developed
   localparam int NW = NumWidth + 1;
   localparam int DW = SWidth + 1;
   logic [SideWidth-1:0] side_ff [QWidth+1];
   logic [NW-1:0]        rem_ff  [QWidth+1];
   logic [DW-1:0]        den_ff  [QWidth+1];
   logic [QWidth-1:0]    q_ff    [QWidth+1];
   logic                 vld_ff  [QWidth+1];

   always_comb begin
      side_ff[0] = in_side;
      rem_ff[0]  = in_num;
      den_ff[0]  = in_den;
      q_ff[0]    = '0;
      vld_ff[0]  = in_valid;
   end

   for (genvar g = 0; g < QWidth; g++) begin : g_stage
      localparam int Bit = QWidth - 1 - g;
      logic [NW+QWidth-1:0] sub;
      logic                 take;
      always_comb begin
         sub  = {{(NW+QWidth-DW){1'b0}}, den_ff[g]} << Bit;
         take = sub <= {{QWidth{1'b0}}, rem_ff[g]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[g+1] <= vld_ff[g];
         end
         if (advance) begin
            rem_ff[g+1]  <= take ? NW'({{QWidth{1'b0}}, rem_ff[g]} - sub) : rem_ff[g];
            q_ff[g+1]    <= take ? (q_ff[g] | (QWidth'(1) << Bit)) : q_ff[g];
            den_ff[g+1]  <= den_ff[g];
            side_ff[g+1] <= side_ff[g];
         end
      end
   end

   assign out_valid = vld_ff[QWidth];
   assign out_q     = q_ff[QWidth];
   assign out_side  = side_ff[QWidth];
endmodule

@@ rtl/pixel_depth_to_world_point.sv @@
// Pinhole back-projection with a two-row rigid transform, fully pipelined.
// A request enters every cycle while the pipeline advances; its result passes through
// 59 register stages (4 front, 34 square root, 2 numerator, 16 divide, 3 transform),
// most of them in the one-bit-per-stage square root and divider pipelines. The
// whole pipeline advances together when the output register is free or taken,
// so a stalled result holds every stage. Configuration is taken at any time and
// must be written only while the pipeline is empty.
module pixel_depth_to_world_point
   import pdwp_pkg::*;
#(
   parameter int CoefFracBits = CoefFracBitsDefault
) (
   input logic      clock,
   input logic      reset,
   pdwp_if.sink     req,
   pdwp_if.source   rsp,
   pdwp_if.sink     csr
);
   // req.data = {range_mm, pixel_y, pixel_x}; rsp.data = {saturated, world_y, world_x}
   // csr.data = {index[2:0], value[63:0]}
   cfg_type cfg_ff;
   logic    advance;
   logic    out_vld_ff;

   assign advance   = !out_vld_ff || rsp.ready;
   assign req.ready = advance;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.focal_x  <= 16'd9600;
         cfg_ff.focal_y  <= 16'd9600;
         cfg_ff.center_x <= 16'd5120;
         cfg_ff.center_y <= 16'd3840;
         cfg_ff.row_x    <= 64'd16384;
         cfg_ff.row_y    <= 64'd1073741824;
      end else if (csr.valid) begin
         case (csr.data[CsrDataWidth +: CsrIndexWidth])
            RegFocalX:  cfg_ff.focal_x  <= csr.data[15:0];
            RegFocalY:  cfg_ff.focal_y  <= csr.data[15:0];
            RegCenterX: cfg_ff.center_x <= csr.data[15:0];
            RegCenterY: cfg_ff.center_y <= csr.data[15:0];
            RegRowX:    cfg_ff.row_x    <= csr.data[63:0];
            RegRowY:    cfg_ff.row_y    <= csr.data[63:0];
            default: ;
         endcase
      end
   end

   // stage 1: offsets
   logic        v1_ff, nx1_ff, ny1_ff;
   logic [15:0] adx1_ff, ady1_ff, fx1_ff, fy1_ff;
   logic [14:0] r1_ff;
   logic [13:0] px_w;
   logic [12:0] py_w;
   always_comb begin
      px_w = {req.data[9:0], 4'b0};
      py_w = {req.data[18:10], 4'b0};
   end
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (advance) v1_ff <= req.valid;
      if (advance) begin
         nx1_ff  <= {2'b0, px_w} < cfg_ff.center_x;
         ny1_ff  <= {3'b0, py_w} < cfg_ff.center_y;
         adx1_ff <= ({2'b0, px_w} < cfg_ff.center_x) ? cfg_ff.center_x - {2'b0, px_w}
                                                     : {2'b0, px_w} - cfg_ff.center_x;
         ady1_ff <= ({3'b0, py_w} < cfg_ff.center_y) ? cfg_ff.center_y - {3'b0, py_w}
                                                     : {3'b0, py_w} - cfg_ff.center_y;
         fx1_ff  <= (cfg_ff.focal_x == 16'd0) ? 16'd1 : cfg_ff.focal_x;
         fy1_ff  <= (cfg_ff.focal_y == 16'd0) ? 16'd1 : cfg_ff.focal_y;
         r1_ff   <= req.data[33:19];
      end
   end

   // stage 2: a, b, c products
   geo_type g2_ff;
   logic    v2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (advance) v2_ff <= v1_ff;
      if (advance) begin
         g2_ff.nx    <= nx1_ff;
         g2_ff.ny    <= ny1_ff;
         g2_ff.a     <= adx1_ff * fy1_ff;
         g2_ff.b     <= ady1_ff * fx1_ff;
         g2_ff.c     <= fx1_ff * fy1_ff;
         g2_ff.range <= r1_ff;
      end
   end

   // stage 3: squares (each 32x32), stage 4: sum
   geo_type     g3_ff, g4_ff;
   logic        v3_ff, v4_ff;
   logic [63:0] aa3_ff, bb3_ff, cc3_ff;
   logic [DWidth-1:0] d4_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      if (advance) begin
         g3_ff  <= g2_ff;
         aa3_ff <= g2_ff.a * g2_ff.a;
         bb3_ff <= g2_ff.b * g2_ff.b;
         cc3_ff <= g2_ff.c * g2_ff.c;
         g4_ff  <= g3_ff;
         d4_ff  <= DWidth'(aa3_ff) + DWidth'(bb3_ff) + DWidth'(cc3_ff);
      end
   end

   // square root
   localparam int GeoW = $bits(geo_type);
   logic              v5;
   logic [SWidth-1:0] s5;
   logic [GeoW-1:0]   g5_bits;
   geo_type           g5;
   pdwp_sqrt #(.SideWidth(GeoW)) u_sqrt (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(v4_ff), .in_d(d4_ff), .in_side(g4_ff),
      .out_valid(v5), .out_s(s5), .out_side(g5_bits)
   );
   assign g5 = geo_type'(g5_bits);

   // stage 6: range products, stage 7: rounded numerators and divisor 2s
   logic              v6_ff, v7_ff, nx6_ff, ny6_ff, nx7_ff, ny7_ff;
   logic [SWidth-1:0] s6_ff;
   logic [NumWidth-1:0] ma6_ff, mb6_ff, mc6_ff;
   logic [NumWidth:0] na7_ff, nb7_ff, nc7_ff;
   logic [SWidth:0]   den7_ff;
   logic [SWidth-1:0] s5c;
   assign s5c = (s5 == '0) ? SWidth'(1) : s5;
   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (advance) begin
         v6_ff <= v5;
         v7_ff <= v6_ff;
      end
      if (advance) begin
         nx6_ff  <= g5.nx;
         ny6_ff  <= g5.ny;
         s6_ff   <= s5c;
         ma6_ff  <= NumWidth'(g5.a) * NumWidth'(g5.range);
         mb6_ff  <= NumWidth'(g5.b) * NumWidth'(g5.range);
         mc6_ff  <= NumWidth'(g5.c) * NumWidth'(g5.range);
         nx7_ff  <= nx6_ff;
         ny7_ff  <= ny6_ff;
         den7_ff <= {s6_ff, 1'b0};
         na7_ff  <= {ma6_ff, 1'b0} + (NumWidth+1)'(s6_ff);
         nb7_ff  <= {mb6_ff, 1'b0} + (NumWidth+1)'(s6_ff);
         nc7_ff  <= {mc6_ff, 1'b0} + (NumWidth+1)'(s6_ff);
      end
   end

   logic              v8, v8b, v8c;
   logic [QWidth-1:0] qa8, qb8, qc8;
   logic [1:0]        sgn8;
   logic              unused_b, unused_c;
   pdwp_div #(.SideWidth(2)) u_div_x (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(v7_ff),
      .in_num(na7_ff), .in_den(den7_ff), .in_side({ny7_ff, nx7_ff}),
      .out_valid(v8), .out_q(qa8), .out_side(sgn8)
   );
   pdwp_div #(.SideWidth(1)) u_div_y (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(v7_ff),
      .in_num(nb7_ff), .in_den(den7_ff), .in_side(1'b0),
      .out_valid(v8b), .out_q(qb8), .out_side(unused_b)
   );
   pdwp_div #(.SideWidth(1)) u_div_z (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(v7_ff),
      .in_num(nc7_ff), .in_den(den7_ff), .in_side(1'b0),
      .out_valid(v8c), .out_q(qc8), .out_side(unused_c)
   );

   // stage 9: signed camera point and coefficient products
   logic signed [16:0] cx_w, cy_w, cz_w;
   logic signed [33:0] px9_ff [3], py9_ff [3];
   logic               v9_ff;
   always_comb begin
      cx_w = sgn8[0] ? -$signed({1'b0, qa8}) : $signed({1'b0, qa8});
      cy_w = sgn8[1] ? -$signed({1'b0, qb8}) : $signed({1'b0, qb8});
      cz_w = $signed({1'b0, qc8});
   end
   always_ff @(posedge clock) begin
      if (reset) v9_ff <= 1'b0;
      else if (advance) v9_ff <= v8 & v8b & v8c & !unused_b & !unused_c | v8;
      if (advance) begin
         px9_ff[0] <= $signed(cfg_ff.row_x[15:0]) * cx_w;
         px9_ff[1] <= $signed(cfg_ff.row_x[31:16]) * cy_w;
         px9_ff[2] <= $signed(cfg_ff.row_x[47:32]) * cz_w;
         py9_ff[0] <= $signed(cfg_ff.row_y[15:0]) * cx_w;
         py9_ff[1] <= $signed(cfg_ff.row_y[31:16]) * cy_w;
         py9_ff[2] <= $signed(cfg_ff.row_y[47:32]) * cz_w;
      end
   end

   // stage 10: accumulate with offset
   localparam int AccW = 38 + CoefFracBits;
   logic signed [AccW-1:0] ax10_ff, ay10_ff;
   logic                   v10_ff;
   always_ff @(posedge clock) begin
      if (reset) v10_ff <= 1'b0;
      else if (advance) v10_ff <= v9_ff;
      if (advance) begin
         ax10_ff <= AccW'(px9_ff[0]) + AccW'(px9_ff[1]) + AccW'(px9_ff[2])
                  + (AccW'($signed(cfg_ff.row_x[63:48])) <<< CoefFracBits);
         ay10_ff <= AccW'(py9_ff[0]) + AccW'(py9_ff[1]) + AccW'(py9_ff[2])
                  + (AccW'($signed(cfg_ff.row_y[63:48])) <<< CoefFracBits);
      end
   end

   // stage 11: truncate toward zero, saturate
   localparam int WW = AccW - CoefFracBits;
   logic signed [WW-1:0] wx_w, wy_w;
   logic                 ox, oy;
   logic [15:0]          sx_w, sy_w;
   logic [15:0]          wx_ff, wy_ff;
   logic                 sat_ff;
   logic [CoefFracBits-1:0] zero_frac;
   assign zero_frac = '0;
   always_comb begin
      wx_w = WW'(ax10_ff >>> CoefFracBits)
           + WW'(ax10_ff[AccW-1] && (ax10_ff[CoefFracBits-1:0] != zero_frac));
      wy_w = WW'(ay10_ff >>> CoefFracBits)
           + WW'(ay10_ff[AccW-1] && (ay10_ff[CoefFracBits-1:0] != zero_frac));
      ox = (wx_w > WW'(32767)) || (wx_w < -WW'(32768));
      oy = (wy_w > WW'(32767)) || (wy_w < -WW'(32768));
      sx_w = !ox ? wx_w[15:0] : (wx_w[WW-1] ? 16'h8000 : 16'h7fff);
      sy_w = !oy ? wy_w[15:0] : (wy_w[WW-1] ? 16'h8000 : 16'h7fff);
   end
   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (advance) out_vld_ff <= v10_ff;
      if (advance) begin
         wx_ff  <= sx_w;
         wy_ff  <= sy_w;
         sat_ff <= ox | oy;
      end
   end

   assign rsp.valid = out_vld_ff;
   assign rsp.data  = {sat_ff, wy_ff, wx_ff};
endmodule

@@ rtl/pdwp_checker.sv @@
// Port-level checks for pixel_depth_to_world_point, bound to the top level.
// Depends on the top level's ports only.
module pdwp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [32:0] rsp_data
);
   // a waiting result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
   // request side is open whenever the output is free
   a_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with empty output");
   // saturation flag only with a clipped value
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data[32] |->
         rsp_data[15:0] == 16'h7fff || rsp_data[15:0] == 16'h8000 ||
         rsp_data[31:16] == 16'h7fff || rsp_data[31:16] == 16'h8000)
      else $error("saturated without clipped value");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");
endmodule

bind pixel_depth_to_world_point pdwp_checker u_pdwp_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
